[sv/pwfd_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pwfd_pkg
// Types, register codes and defaults shared by the pulse width frame decoder.
// ---------------------------------------------------------------------------
package pwfd_pkg;

	localparam int EDGES_PER_FRAME_DEF = 80;
	localparam int FRAME_BITS_DEF      = 40;

	localparam int TIME_W    = 32;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam int TALLY_W   = 7;
	localparam int BYTE_W    = 8;
	localparam int WORD_W    = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO_LOW   = 3'd0,
		REG_ZERO_HIGH  = 3'd1,
		REG_ONE_LOW    = 3'd2,
		REG_ONE_HIGH   = 3'd3,
		REG_START_LOW  = 3'd4,
		REG_START_HIGH = 3'd5
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] ZERO_LOW_RST   = 10'd10;
	localparam logic [CFG_W-1:0] ZERO_HIGH_RST  = 10'd40;
	localparam logic [CFG_W-1:0] ONE_LOW_RST    = 10'd55;
	localparam logic [CFG_W-1:0] ONE_HIGH_RST   = 10'd90;
	localparam logic [CFG_W-1:0] START_LOW_RST  = 10'd30;
	localparam logic [CFG_W-1:0] START_HIGH_RST = 10'd70;

	typedef struct packed {
		logic [CFG_W-1:0] zero_low_us;
		logic [CFG_W-1:0] zero_high_us;
		logic [CFG_W-1:0] one_low_us;
		logic [CFG_W-1:0] one_high_us;
		logic [CFG_W-1:0] start_low_us;
		logic [CFG_W-1:0] start_high_us;
	} pwfd_cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] edge_time;
		logic              frame_start;
	} pwfd_edge_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  humidity_whole;
		logic [BYTE_W-1:0]  humidity_frac;
		logic [BYTE_W-1:0]  temp_whole;
		logic [BYTE_W-1:0]  temp_frac;
		logic [BYTE_W-1:0]  check_byte;
		logic [TALLY_W-1:0] pulse_errors;
		logic               frame_ok;
	} pwfd_frame_t;

endpackage
`default_nettype wire

[sv/pwfd_stream_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pwfd_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ---------------------------------------------------------------------------
interface pwfd_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/pwfd_cfg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pwfd_cfg
// Timing window registers, written through a plain write port.
// ---------------------------------------------------------------------------
module pwfd_cfg
	import pwfd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output pwfd_cfg_t                 cfg
);

	pwfd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_low_us   <= ZERO_LOW_RST;
			cfg_q.zero_high_us  <= ZERO_HIGH_RST;
			cfg_q.one_low_us    <= ONE_LOW_RST;
			cfg_q.one_high_us   <= ONE_HIGH_RST;
			cfg_q.start_low_us  <= START_LOW_RST;
			cfg_q.start_high_us <= START_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ZERO_LOW:   cfg_q.zero_low_us   <= cfg_data;
				REG_ZERO_HIGH:  cfg_q.zero_high_us  <= cfg_data;
				REG_ONE_LOW:    cfg_q.one_low_us    <= cfg_data;
				REG_ONE_HIGH:   cfg_q.one_high_us   <= cfg_data;
				REG_START_LOW:  cfg_q.start_low_us  <= cfg_data;
				REG_START_HIGH: cfg_q.start_high_us <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[sv/pwfd_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pwfd_core
// Edge input register, gap classification, bit shift and result register.
// ---------------------------------------------------------------------------
module pwfd_core
	import pwfd_pkg::*;
#(
	parameter int EDGES_PER_FRAME = EDGES_PER_FRAME_DEF,
	parameter int FRAME_BITS      = FRAME_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire pwfd_cfg_t  cfg,
	pwfd_stream_if.sink     edges,
	pwfd_stream_if.source   frames
);

	localparam int CntW = $clog2(EDGES_PER_FRAME + 1);
	localparam logic [TALLY_W-1:0] TallyMax = '1;

	// input stage
	logic       s1_valid_q;
	pwfd_edge_t edge_s1;
	logic       advance;

	// frame state
	logic [CntW-1:0]       edge_count_q;
	logic [TIME_W-1:0]     last_edge_q;
	logic [FRAME_BITS-1:0] shift_q;
	logic [TALLY_W-1:0]    tally_q;

	// result register
	logic        out_valid_q;
	pwfd_frame_t out_q;

	logic [TIME_W-1:0]     gap;
	logic                  in_zero, in_one, in_start;
	logic                  data_gap, gap_err, bit_val;
	logic [CntW-1:0]       count_inc;
	logic                  active, done, emit;
	logic [FRAME_BITS-1:0] shift_nxt;
	logic [TALLY_W-1:0]    tally_nxt;
	logic [WORD_W-1:0]     word;
	logic [BYTE_W-1:0]     byte_sum;
	pwfd_frame_t           res;

	assign advance      = s1_valid_q && (!out_valid_q || frames.ready);
	assign edges.ready  = !s1_valid_q || advance;
	assign frames.valid = out_valid_q;
	assign frames.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (edges.valid && edges.ready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (edges.valid && edges.ready) begin
			edge_s1 <= edges.data;
		end
	end

	always_comb begin
		gap      = edge_s1.edge_time - last_edge_q;
		in_zero  = gap > TIME_W'(cfg.zero_low_us) && gap < TIME_W'(cfg.zero_high_us);
		in_one   = gap > TIME_W'(cfg.one_low_us) && gap < TIME_W'(cfg.one_high_us);
		in_start = gap > TIME_W'(cfg.start_low_us) && gap < TIME_W'(cfg.start_high_us);
		// gaps are numbered from zero; even gap while the edge count is odd
		data_gap = edge_count_q[0];
		gap_err  = data_gap ? !(in_zero || in_one) : !in_start;
		bit_val  = !in_zero && in_one;

		active    = edge_count_q != '0;
		count_inc = edge_count_q + CntW'(1);
		done      = count_inc >= CntW'(EDGES_PER_FRAME);
		emit      = !edge_s1.frame_start && active && done;

		shift_nxt = data_gap ? {shift_q[FRAME_BITS-2:0], bit_val} : shift_q;
		tally_nxt = (gap_err && tally_q != TallyMax) ? tally_q + TALLY_W'(1) : tally_q;
	end

	generate
		if (FRAME_BITS >= WORD_W) begin : g_word_top
			assign word = shift_nxt[FRAME_BITS-1 -: WORD_W];
		end else begin : g_word_pad
			assign word = {shift_nxt, {(WORD_W - FRAME_BITS){1'b0}}};
		end
	endgenerate

	always_comb begin
		res.humidity_whole = word[39:32];
		res.humidity_frac  = word[31:24];
		res.temp_whole     = word[23:16];
		res.temp_frac      = word[15:8];
		res.check_byte     = word[7:0];
		byte_sum = res.humidity_whole + res.humidity_frac + res.temp_whole + res.temp_frac;
		res.pulse_errors   = tally_nxt;
		res.frame_ok       = (tally_nxt == '0) && (byte_sum == res.check_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
			last_edge_q  <= '0;
			shift_q      <= '0;
			tally_q      <= '0;
		end else if (advance) begin
			if (edge_s1.frame_start) begin
				edge_count_q <= CntW'(1);
				last_edge_q  <= edge_s1.edge_time;
				shift_q      <= '0;
				tally_q      <= '0;
			end else if (active) begin
				edge_count_q <= done ? '0 : count_inc;
				last_edge_q  <= edge_s1.edge_time;
				shift_q      <= shift_nxt;
				tally_q      <= tally_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (frames.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

endmodule
`default_nettype wire

[sv/pulse_width_frame_decoder.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pulse_width_frame_decoder
// Decodes a pulse-width framed 40-bit sensor word from line edge timestamps.
// ---------------------------------------------------------------------------
// One edge timestamp is taken per clock while the input is not stalled. Each
// beat is held in an input register, where a single 32-bit subtract, three
// window compares and a one-bit shift update the frame state; the last edge
// of a frame loads the result register from the input register, and the
// frame beat is presented from the result register. The sustained rate is
// one edge per cycle; the input stalls only while a result sits unread in
// the result register. A frame_start edge restarts the frame at any time,
// and edges outside a frame are dropped. Window registers are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while no
// edge is in flight, as the block itself does not enforce this.
module pulse_width_frame_decoder
	import pwfd_pkg::*;
#(
	parameter int EDGES_PER_FRAME = EDGES_PER_FRAME_DEF,
	parameter int FRAME_BITS      = FRAME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	pwfd_stream_if.sink               edges,
	pwfd_stream_if.source             frames
);

	pwfd_cfg_t cfg;

	pwfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pwfd_core #(
		.EDGES_PER_FRAME (EDGES_PER_FRAME),
		.FRAME_BITS      (FRAME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.edges  (edges),
		.frames (frames)
	);

`ifndef SYNTHESIS
	a_ok_no_errors: assert property (@(posedge clk) disable iff (!arst_n)
		frames.valid && frames.data.frame_ok |-> frames.data.pulse_errors == '0)
		else $error("frame_ok set with nonzero error count");

	a_ok_checksum: assert property (@(posedge clk) disable iff (!arst_n)
		frames.valid && frames.data.frame_ok |->
		BYTE_W'(frames.data.humidity_whole + frames.data.humidity_frac +
			frames.data.temp_whole + frames.data.temp_frac) == frames.data.check_byte)
		else $error("frame_ok set with checksum mismatch");

	a_edge_ready_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!frames.valid |-> edges.ready)
		else $error("edge input stalled with empty result register");
`endif

endmodule
`default_nettype wire

[test/pulse_width_frame_decoder_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pulse_width_frame_decoder_test
// Self-checking bench for the pulse width frame decoder: queued edge beats,
// an edge-level decode model, and a frame checker with random back-pressure.
// ---------------------------------------------------------------------------
module pulse_width_frame_decoder_test;
	import pwfd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef enum int {FK_CLEAN, FK_BAD_SUM, FK_GLITCH, FK_CUT} frame_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	pwfd_stream_if #(.T(pwfd_edge_t))  edges_ch ();
	pwfd_stream_if #(.T(pwfd_frame_t)) frames_ch ();

	pulse_width_frame_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.edges     (edges_ch),
		.frames    (frames_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decode model state
	logic [CFG_W-1:0]   win_us [0:5];
	logic [TIME_W-1:0]  last_edge_us = '0;
	int                 edges_in = 0;
	logic [WORD_W-1:0]  rx_word = '0;
	logic [TALLY_W-1:0] gap_errors = '0;

	pwfd_edge_t  edges_pending [$];
	pwfd_frame_t frames_due [$];
	int          mismatches = 0;
	int          edges_taken = 0;
	int          n_items = 0;
	logic [9:0]  stall_left;
	logic        stall_done;
	logic        calm;

	assign calm = edges_taken >= 900 && edges_taken < 1400;

	function automatic logic in_window(logic [TIME_W-1:0] gap, cfg_reg_t lo, cfg_reg_t hi);
		return gap > win_us[lo] && gap < win_us[hi];
	endfunction

	task automatic decode_edge(pwfd_edge_t e);
		logic [TIME_W-1:0] gap;
		logic              data_bit;
		logic [BYTE_W-1:0] sum;
		pwfd_frame_t       f;
		if (e.frame_start) begin
			last_edge_us = e.edge_time;
			edges_in = 1;
			rx_word = '0;
			gap_errors = '0;
			return;
		end
		if (edges_in == 0)
			return;
		gap = e.edge_time - last_edge_us;
		last_edge_us = e.edge_time;
		if (edges_in % 2 == 0) begin
			if (!in_window(gap, REG_START_LOW, REG_START_HIGH) && gap_errors != '1)
				gap_errors++;
		end else begin
			data_bit = 1'b0;
			if (in_window(gap, REG_ZERO_LOW, REG_ZERO_HIGH)) begin
				data_bit = 1'b0;
			end else if (in_window(gap, REG_ONE_LOW, REG_ONE_HIGH)) begin
				data_bit = 1'b1;
			end else if (gap_errors != '1) begin
				gap_errors++;
			end
			rx_word = {rx_word[WORD_W-2:0], data_bit};
		end
		edges_in++;
		if (edges_in < EDGES_PER_FRAME_DEF)
			return;
		edges_in = 0;
		f.humidity_whole = rx_word[39:32];
		f.humidity_frac  = rx_word[31:24];
		f.temp_whole     = rx_word[23:16];
		f.temp_frac      = rx_word[15:8];
		f.check_byte     = rx_word[7:0];
		sum = f.humidity_whole + f.humidity_frac + f.temp_whole + f.temp_frac;
		f.pulse_errors = gap_errors;
		f.frame_ok = gap_errors == '0 && sum == f.check_byte;
		frames_due.push_back(f);
	endtask

	task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	task automatic check_frame(pwfd_frame_t got);
		pwfd_frame_t want;
		if (frames_due.size() == 0) begin
			$display("%0t ns: frame expected none got %p", $time, got);
			mismatches++;
			return;
		end
		want = frames_due.pop_front();
		check_field("humidity_whole", want.humidity_whole, got.humidity_whole);
		check_field("humidity_frac", want.humidity_frac, got.humidity_frac);
		check_field("temp_whole", want.temp_whole, got.temp_whole);
		check_field("temp_frac", want.temp_frac, got.temp_frac);
		check_field("check_byte", want.check_byte, got.check_byte);
		check_field("pulse_errors", want.pulse_errors, got.pulse_errors);
		check_field("frame_ok", want.frame_ok, got.frame_ok);
	endtask

	// edge driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_ch.valid <= 1'b0;
			edges_ch.data <= '0;
		end else if (!edges_ch.valid || edges_ch.ready) begin
			if (edges_ch.valid) begin
				decode_edge(edges_ch.data);
				edges_taken <= edges_taken + 1;
			end
			if (edges_pending.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
				edges_ch.valid <= 1'b1;
				edges_ch.data <= edges_pending.pop_front();
			end else begin
				edges_ch.valid <= 1'b0;
			end
		end
	end

	// one long receiver hold while plenty of edges are queued
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= '0;
			stall_done <= 1'b0;
		end else if (stall_left != '0) begin
			stall_left <= stall_left - 1'b1;
		end else if (!stall_done && edges_pending.size() > 200) begin
			stall_left <= 10'd500;
			stall_done <= 1'b1;
		end
	end

	// frame monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_ch.ready <= 1'b0;
		end else begin
			if (frames_ch.valid && frames_ch.ready)
				check_frame(frames_ch.data);
			frames_ch.ready <= stall_left == '0 && (calm || $urandom_range(99) >= 30);
		end
	end

	task automatic queue_edge(logic [TIME_W-1:0] t, logic s, logic ignored);
		edges_pending.push_back('{edge_time: t, frame_start: s});
		if (!ignored)
			n_items++;
	endtask

	function automatic logic [TIME_W-1:0] pick_gap(cfg_reg_t lo_reg, cfg_reg_t hi_reg,
			frame_kind_t kind);
		int lo;
		int hi;
		lo = win_us[lo_reg];
		hi = win_us[hi_reg];
		if (kind == FK_GLITCH && $urandom_range(99) < 8) begin
			case ($urandom_range(4))
				0: return lo;
				1: return hi;
				2: return '0;
				3: return $urandom;
				default: return $urandom_range(1100);
			endcase
		end
		if (hi > lo + 1)
			return $urandom_range(hi - 1, lo + 1);
		return $urandom_range(1100);
	endfunction

	task automatic queue_frame(frame_kind_t kind);
		logic [BYTE_W-1:0] b [5];
		logic [WORD_W-1:0] bits;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] gap;
		int                last_gap;
		for (int i = 0; i < 4; i++)
			b[i] = $urandom_range(255);
		b[4] = b[0] + b[1] + b[2] + b[3];
		if (kind == FK_BAD_SUM)
			b[4] = b[4] + $urandom_range(255, 1);
		bits = {b[0], b[1], b[2], b[3], b[4]};
		t = $urandom_range(99) < 10 ? 32'hFFFF_FFFF - $urandom_range(3000) : $urandom;
		queue_edge(t, 1'b1, 1'b0);
		last_gap = kind == FK_CUT ? $urandom_range(77) : EDGES_PER_FRAME_DEF - 2;
		for (int g = 0; g <= last_gap; g++) begin
			if (g % 2 != 0) begin
				gap = pick_gap(REG_START_LOW, REG_START_HIGH, kind);
			end else if (bits[WORD_W-1-g/2]) begin
				gap = pick_gap(REG_ONE_LOW, REG_ONE_HIGH, kind);
			end else begin
				gap = pick_gap(REG_ZERO_LOW, REG_ZERO_HIGH, kind);
			end
			t = t + gap;
			queue_edge(t, 1'b0, 1'b0);
		end
		if (kind != FK_CUT) begin
			// stray edges between frames
			if ($urandom_range(99) < 20)
				repeat ($urandom_range(3, 1))
					queue_edge($urandom, 1'b0, 1'b1);
		end
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx <= REG_START_HIGH)
			win_us[idx] = val;
	endtask

	task automatic set_windows(int zl, int zh, int ol, int oh, int sl, int sh);
		put_reg(REG_ZERO_LOW, CFG_W'(zl));
		put_reg(REG_ZERO_HIGH, CFG_W'(zh));
		put_reg(REG_ONE_LOW, CFG_W'(ol));
		put_reg(REG_ONE_HIGH, CFG_W'(oh));
		put_reg(REG_START_LOW, CFG_W'(sl));
		put_reg(REG_START_HIGH, CFG_W'(sh));
		put_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom_range(1023)));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (edges_pending.size() != 0 || edges_ch.valid || frames_due.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		logic [TIME_W-1:0] t;
		int                zl;
		int                zh;
		int                ol;
		int                r;
		int                n;
		logic [TIME_W-1:0] probe_gaps [17];
		probe_gaps = '{10, 30, 11, 70, 40, 31, 39, 69, 55, 50, 56, 50, 89, 50, 90, 50,
			32'hFFFF_FFFF};
		win_us = '{ZERO_LOW_RST, ZERO_HIGH_RST, ONE_LOW_RST, ONE_HIGH_RST,
			START_LOW_RST, START_HIGH_RST};
		edges_ch.valid = 1'b0;
		edges_ch.data = '0;
		frames_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// window bounds at reset values, stray edges, timestamp wrap, restart
		queue_edge('0, 1'b0, 1'b1);
		queue_edge('1, 1'b0, 1'b1);
		t = 32'hFFFF_FFF0;
		queue_edge(t, 1'b1, 1'b0);
		foreach (probe_gaps[i]) begin
			t = t + probe_gaps[i];
			queue_edge(t, 1'b0, 1'b0);
		end
		t = $urandom;
		queue_edge(t, 1'b1, 1'b0);
		queue_edge(t + 20, 1'b0, 1'b0);

		for (int phase = 1; n_items < 1850; phase++) begin
			wait_idle();
			case (phase)
				1: set_windows(ZERO_LOW_RST, ZERO_HIGH_RST, ONE_LOW_RST, ONE_HIGH_RST,
					START_LOW_RST, START_HIGH_RST);
				2: set_windows(0, 0, 0, 0, 0, 0);
				3: set_windows(1023, 1023, 1023, 1023, 1023, 1023);
				4: set_windows(0, 1023, 0, 1023, 0, 1023);
				5: set_windows(900, 950, 960, 1023, 980, 1023);
				default: begin
					zl = $urandom_range(60);
					zh = zl + $urandom_range(60, 2);
					ol = phase % 4 == 0 ? $urandom_range(zh) : zh + $urandom_range(40);
					r = $urandom_range(100);
					set_windows(zl, zh, ol, ol + $urandom_range(120, 2), r,
						r + $urandom_range(300, 2));
				end
			endcase
			n = phase >= 2 && phase <= 4 ? 2 : 4;
			repeat (n) begin
				r = $urandom_range(99);
				if (r < 70)
					queue_frame(FK_CLEAN);
				else if (r < 80)
					queue_frame(FK_BAD_SUM);
				else if (r < 92)
					queue_frame(FK_GLITCH);
				else
					queue_frame(FK_CUT);
			end
		end
		wait_idle();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
